FILE: src/wls_pkg.sv
package wls_pkg;

  // Width of each configuration register.
  localparam int CFG_W = 24;
  // Default countdown width.
  localparam int TIMER_BITS_DEF = 24;
  // APB address and data widths.
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Link states as they appear on link_state.
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_CONNECTING = 3'd1;
  localparam logic [2:0] ST_ONLINE     = 3'd2;
  localparam logic [2:0] ST_RETRY      = 3'd3;
  localparam logic [2:0] ST_PORTAL     = 3'd4;

  // Event codes carried by func.
  localparam logic [2:0] FN_TICK      = 3'd0;
  localparam logic [2:0] FN_GOT_ADDR  = 3'd1;
  localparam logic [2:0] FN_DISCONN   = 3'd2;
  localparam logic [2:0] FN_START     = 3'd3;
  localparam logic [2:0] FN_RECONNECT = 3'd4;
  localparam logic [2:0] FN_SET_CRED  = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CONNECT_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_AP_LINGER       = 2'd2;
  localparam logic [1:0] REG_AP_WINDOW       = 2'd3;

  localparam logic [CFG_W-1:0] RST_CONNECT_TIMEOUT = CFG_W'(20 * 1000);
  localparam logic [CFG_W-1:0] RST_RETRY_INTERVAL  = CFG_W'(60 * 1000);
  localparam logic [CFG_W-1:0] RST_AP_LINGER       = CFG_W'(5 * 1000);
  localparam logic [CFG_W-1:0] RST_AP_WINDOW       = CFG_W'(10 * 60 * 1000);

  typedef struct packed {
    logic [2:0] func;
    logic       have_credentials;
    logic       ssid_present;
    logic       store_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0] link_state;
    logic       ap_active;
    logic       connect_pulse;
    logic       abort_pulse;
    logic       accepted;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] connect_timeout_ms;
    logic [CFG_W-1:0] retry_interval_ms;
    logic [CFG_W-1:0] ap_linger_ms;
    logic [CFG_W-1:0] ap_window_ms;
  } cfg_regs_t;

endpackage

FILE: src/wls_if.sv
interface wls_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic       have_credentials;
  logic       ssid_present;
  logic       store_ok;

  modport source (output valid, output func, output have_credentials,
                  output ssid_present, output store_ok, input ready);
  modport sink (input valid, input func, input have_credentials,
                input ssid_present, input store_ok, output ready);
endinterface

interface wls_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] link_state;
  logic       ap_active;
  logic       connect_pulse;
  logic       abort_pulse;
  logic       accepted;

  modport source (output valid, output link_state, output ap_active,
                  output connect_pulse, output abort_pulse, output accepted,
                  input ready);
  modport sink (input valid, input link_state, input ap_active,
                input connect_pulse, input abort_pulse, input accepted,
                output ready);
endinterface

FILE: src/wls_cfg.sv
module wls_cfg
  import wls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  cfg_regs_t  cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.connect_timeout_ms <= RST_CONNECT_TIMEOUT;
      cfg_r.retry_interval_ms  <= RST_RETRY_INTERVAL;
      cfg_r.ap_linger_ms       <= RST_AP_LINGER;
      cfg_r.ap_window_ms       <= RST_AP_WINDOW;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CONNECT_TIMEOUT: cfg_r.connect_timeout_ms <= pwdata[CFG_W-1:0];
        REG_RETRY_INTERVAL:  cfg_r.retry_interval_ms  <= pwdata[CFG_W-1:0];
        REG_AP_LINGER:       cfg_r.ap_linger_ms       <= pwdata[CFG_W-1:0];
        REG_AP_WINDOW:       cfg_r.ap_window_ms       <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CONNECT_TIMEOUT: prdata = APB_DW'(cfg_r.connect_timeout_ms);
      REG_RETRY_INTERVAL:  prdata = APB_DW'(cfg_r.retry_interval_ms);
      REG_AP_LINGER:       prdata = APB_DW'(cfg_r.ap_linger_ms);
      REG_AP_WINDOW:       prdata = APB_DW'(cfg_r.ap_window_ms);
    endcase
  end

endmodule

FILE: src/wls_core.sv
module wls_core
  import wls_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      upd,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t res
);

  localparam int WW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [WW-1:0] TMAX_W = WW'({TIMER_BITS{1'b1}});

  logic [2:0]            mode_r, mode_nxt;
  logic                  addr_r, addr_nxt;
  logic                  ap_up_r, ap_up_nxt;
  logic                  ap_used_r, ap_used_nxt;
  logic                  cred_r, cred_nxt;
  logic [TIMER_BITS-1:0] conn_r, conn_nxt;
  logic [TIMER_BITS-1:0] retry_r, retry_nxt;
  logic [TIMER_BITS-1:0] ap_r, ap_nxt;
  logic [TIMER_BITS-1:0] linger_r, linger_nxt;
  logic                  pc, pa, ok;

  // A register value beyond the countdown range saturates to its maximum.
  function automatic logic [TIMER_BITS-1:0] load_timer(input logic [CFG_W-1:0] v);
    logic [WW-1:0] w;
    w = WW'(v);
    return (w > TMAX_W) ? TIMER_BITS'(TMAX_W) : TIMER_BITS'(w);
  endfunction

  function automatic logic [TIMER_BITS-1:0] count_down(input logic [TIMER_BITS-1:0] v);
    return (v == '0) ? '0 : v - TIMER_BITS'(1);
  endfunction

  always_comb begin
    mode_nxt    = mode_r;
    addr_nxt    = addr_r;
    ap_up_nxt   = ap_up_r;
    ap_used_nxt = ap_used_r;
    cred_nxt    = cred_r;
    conn_nxt    = conn_r;
    retry_nxt   = retry_r;
    ap_nxt      = ap_r;
    linger_nxt  = linger_r;
    pc          = 1'b0;
    pa          = 1'b0;
    ok          = 1'b0;

    unique case (item.func)
      FN_TICK: begin
        conn_nxt   = count_down(conn_r);
        retry_nxt  = count_down(retry_r);
        ap_nxt     = count_down(ap_r);
        linger_nxt = count_down(linger_r);
        unique case (mode_r)
          ST_CONNECTING: begin
            if (addr_r) begin
              mode_nxt    = ST_ONLINE;
              linger_nxt  = load_timer(cfg.ap_linger_ms);
              ap_used_nxt = 1'b0;
            end else if (conn_nxt == '0) begin
              pa        = 1'b1;
              mode_nxt  = ST_RETRY;
              retry_nxt = load_timer(cfg.retry_interval_ms);
              if (!ap_used_r) begin
                if (!ap_up_r) begin
                  ap_up_nxt = 1'b1;
                  ap_nxt    = load_timer(cfg.ap_window_ms);
                end
                ap_used_nxt = 1'b1;
              end
            end
          end
          ST_ONLINE: begin
            if (!addr_r) begin
              mode_nxt  = ST_RETRY;
              retry_nxt = load_timer(cfg.retry_interval_ms);
              if (!ap_used_r) begin
                if (!ap_up_r) begin
                  ap_up_nxt = 1'b1;
                  ap_nxt    = load_timer(cfg.ap_window_ms);
                end
                ap_used_nxt = 1'b1;
              end
            end else if (ap_up_r && linger_nxt == '0) begin
              ap_up_nxt = 1'b0;
            end
          end
          ST_RETRY: begin
            if (ap_up_r && ap_nxt == '0) begin
              ap_up_nxt = 1'b0;
            end
            if (retry_nxt == '0) begin
              addr_nxt = 1'b0;
              mode_nxt = ST_CONNECTING;
              conn_nxt = load_timer(cfg.connect_timeout_ms);
              pc       = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      FN_GOT_ADDR: addr_nxt = 1'b1;
      FN_DISCONN:  addr_nxt = 1'b0;
      FN_START: begin
        cred_nxt = item.have_credentials;
        if (item.have_credentials) begin
          addr_nxt = 1'b0;
          mode_nxt = ST_CONNECTING;
          conn_nxt = load_timer(cfg.connect_timeout_ms);
          pc       = 1'b1;
        end else begin
          if (!ap_up_r) begin
            ap_up_nxt = 1'b1;
            ap_nxt    = load_timer(cfg.ap_window_ms);
          end
          ap_used_nxt = 1'b1;
          mode_nxt    = ST_PORTAL;
        end
      end
      FN_RECONNECT: begin
        if (cred_r) begin
          addr_nxt = 1'b0;
          mode_nxt = ST_CONNECTING;
          conn_nxt = load_timer(cfg.connect_timeout_ms);
          pc       = 1'b1;
          ok       = 1'b1;
        end
      end
      FN_SET_CRED: begin
        if (item.ssid_present) begin
          cred_nxt = 1'b1;
          if (item.store_ok) begin
            ap_used_nxt = 1'b1;
            addr_nxt    = 1'b0;
            mode_nxt    = ST_CONNECTING;
            conn_nxt    = load_timer(cfg.connect_timeout_ms);
            pc          = 1'b1;
            ok          = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    res.link_state    = mode_nxt;
    res.ap_active     = ap_up_nxt;
    res.connect_pulse = pc;
    res.abort_pulse   = pa;
    res.accepted      = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ST_IDLE;
      addr_r    <= 1'b0;
      ap_up_r   <= 1'b0;
      ap_used_r <= 1'b0;
      cred_r    <= 1'b0;
      conn_r    <= '0;
      retry_r   <= '0;
      ap_r      <= '0;
      linger_r  <= '0;
    end else if (upd) begin
      mode_r    <= mode_nxt;
      addr_r    <= addr_nxt;
      ap_up_r   <= ap_up_nxt;
      ap_used_r <= ap_used_nxt;
      cred_r    <= cred_nxt;
      conn_r    <= conn_nxt;
      retry_r   <= retry_nxt;
      ap_r      <= ap_nxt;
      linger_r  <= linger_nxt;
    end
  end

endmodule

FILE: src/wireless_link_supervisor.sv
// A result passes through the input register and then the result register
// before it is presented on the result channel.
// Throughput: one item per cycle while the result channel is not stalled.
// Reset: synchronous, active low; link state idle, all flags and countdowns
// zero, configuration registers at their defaults; no clearing pass.
module wireless_link_supervisor
  import wls_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  wls_in_if.sink            in_chan,
  wls_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // The input stage holds one accepted item. It moves into the result
  // register, and commits its state update, whenever the result register
  // is empty or its current result is being taken in the same cycle.
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t core_res;
  cfg_regs_t cfg;
  logic      out_free;
  logic      s1_adv;
  logic      in_fire;

  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_adv   = s1_valid_r && out_free;
  // New items are taken while the input stage is empty or draining.
  assign in_chan.ready = !s1_valid_r || out_free;
  assign in_fire  = in_chan.valid && in_chan.ready;

  wls_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The core holds the supervisor state and evaluates one event from the
  // input stage; its state is committed only when that event advances.
  wls_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s1_adv),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (core_res)
  );

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.func             <= in_chan.func;
      s1_item_r.have_credentials <= in_chan.have_credentials;
      s1_item_r.ssid_present     <= in_chan.ssid_present;
      s1_item_r.store_ok         <= in_chan.store_ok;
    end
    if (s1_adv) begin
      out_item_r <= core_res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.link_state    = out_item_r.link_state;
  assign out_chan.ap_active     = out_item_r.ap_active;
  assign out_chan.connect_pulse = out_item_r.connect_pulse;
  assign out_chan.abort_pulse   = out_item_r.abort_pulse;
  assign out_chan.accepted      = out_item_r.accepted;

`ifndef SYNTHESIS
  // An abort drops into retry wait, so it never starts a new attempt too.
  a_no_abort_and_connect: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.connect_pulse && out_item_r.abort_pulse))
    else $error("connect and abort pulses in one result");

  // Every accepted request starts a connection attempt.
  a_accept_connects: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.accepted) |-> out_item_r.connect_pulse)
    else $error("accepted without a connection attempt");

  // A started attempt always leaves the link in the connecting state.
  a_connect_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.connect_pulse) |->
      (out_item_r.link_state == ST_CONNECTING))
    else $error("connect pulse outside connecting state");

  // A held item in the input stage is never dropped while the output stalls.
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
    else $error("input stage lost an item");
`endif

endmodule

FILE: verif/wls_link_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port. It predicts one status report per
// input transfer and compares every result transfer against the oldest prediction.
module wls_link_checker
  import wls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  wls_in_if                 in_mon,
  wls_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                pending,
  output int                fail_count
);

  localparam int TW = TIMER_BITS_DEF;

  cfg_regs_t   cfg;
  logic [2:0]  mode;
  logic        address_held;
  logic        ap_up;
  logic        ap_used;
  logic        creds_known;
  logic        pulse_connect;
  logic        pulse_abort;
  logic [TW-1:0] connect_left;
  logic [TW-1:0] retry_left;
  logic [TW-1:0] ap_left;
  logic [TW-1:0] linger_left;

  out_item_t predicted_status[$];

  // The countdowns are as wide as the registers, so a load never needs to saturate.
  function automatic logic [TW-1:0] step_down(logic [TW-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic void raise_ap();
    if (!ap_up) begin
      ap_up   = 1'b1;
      ap_left = cfg.ap_window_ms;
    end
  endfunction

  function automatic void begin_connect();
    address_held  = 1'b0;
    mode          = ST_CONNECTING;
    connect_left  = cfg.connect_timeout_ms;
    pulse_connect = 1'b1;
  endfunction

  function automatic void enter_offline();
    mode       = ST_RETRY;
    retry_left = cfg.retry_interval_ms;
    if (!ap_used) begin
      raise_ap();
      ap_used = 1'b1;
    end
  endfunction

  function automatic out_item_t advance_link(in_item_t ev);
    out_item_t res;
    logic      ok;
    ok            = 1'b0;
    pulse_connect = 1'b0;
    pulse_abort   = 1'b0;
    case (ev.func)
      FN_TICK: begin
        connect_left = step_down(connect_left);
        retry_left   = step_down(retry_left);
        ap_left      = step_down(ap_left);
        linger_left  = step_down(linger_left);
        case (mode)
          ST_CONNECTING: begin
            if (address_held) begin
              mode        = ST_ONLINE;
              linger_left = cfg.ap_linger_ms;
              ap_used     = 1'b0;
            end else if (connect_left == '0) begin
              pulse_abort = 1'b1;
              enter_offline();
            end
          end
          ST_ONLINE: begin
            if (!address_held) enter_offline();
            else if (ap_up && linger_left == '0) ap_up = 1'b0;
          end
          ST_RETRY: begin
            if (ap_up && ap_left == '0) ap_up = 1'b0;
            if (retry_left == '0) begin_connect();
          end
          default: ;
        endcase
      end
      FN_GOT_ADDR: address_held = 1'b1;
      FN_DISCONN:  address_held = 1'b0;
      FN_START: begin
        creds_known = ev.have_credentials;
        if (ev.have_credentials) begin
          begin_connect();
        end else begin
          raise_ap();
          ap_used = 1'b1;
          mode    = ST_PORTAL;
        end
      end
      FN_RECONNECT: begin
        if (creds_known) begin
          begin_connect();
          ok = 1'b1;
        end
      end
      FN_SET_CRED: begin
        if (ev.ssid_present) begin
          creds_known = 1'b1;
          if (ev.store_ok) begin
            ap_used = 1'b1;
            begin_connect();
            ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.link_state    = mode;
    res.ap_active     = ap_up;
    res.connect_pulse = pulse_connect;
    res.abort_pulse   = pulse_abort;
    res.accepted      = ok;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    in_item_t  ev;
    if (!rst_n) begin
      cfg.connect_timeout_ms = RST_CONNECT_TIMEOUT;
      cfg.retry_interval_ms  = RST_RETRY_INTERVAL;
      cfg.ap_linger_ms       = RST_AP_LINGER;
      cfg.ap_window_ms       = RST_AP_WINDOW;
      mode         = ST_IDLE;
      address_held = 1'b0;
      ap_up        = 1'b0;
      ap_used      = 1'b0;
      creds_known  = 1'b0;
      connect_left = '0;
      retry_left   = '0;
      ap_left      = '0;
      linger_left  = '0;
      predicted_status.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CONNECT_TIMEOUT: cfg.connect_timeout_ms = pwdata[CFG_W-1:0];
          REG_RETRY_INTERVAL:  cfg.retry_interval_ms  = pwdata[CFG_W-1:0];
          REG_AP_LINGER:       cfg.ap_linger_ms       = pwdata[CFG_W-1:0];
          REG_AP_WINDOW:       cfg.ap_window_ms       = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (predicted_status.size() == 0) begin
          $error("%m: result transfer with nothing expected (link_state %0d)",
                 out_mon.link_state);
          fail_count++;
        end else begin
          want = predicted_status.pop_front();
          if (out_mon.link_state !== want.link_state) begin
            $error("%m: link_state expected %0d, got %0d",
                   want.link_state, out_mon.link_state);
            fail_count++;
          end
          if (out_mon.ap_active !== want.ap_active) begin
            $error("%m: ap_active expected %0d, got %0d",
                   want.ap_active, out_mon.ap_active);
            fail_count++;
          end
          if (out_mon.connect_pulse !== want.connect_pulse) begin
            $error("%m: connect_pulse expected %0d, got %0d",
                   want.connect_pulse, out_mon.connect_pulse);
            fail_count++;
          end
          if (out_mon.abort_pulse !== want.abort_pulse) begin
            $error("%m: abort_pulse expected %0d, got %0d",
                   want.abort_pulse, out_mon.abort_pulse);
            fail_count++;
          end
          if (out_mon.accepted !== want.accepted) begin
            $error("%m: accepted expected %0d, got %0d",
                   want.accepted, out_mon.accepted);
            fail_count++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        ev.func             = in_mon.func;
        ev.have_credentials = in_mon.have_credentials;
        ev.ssid_present     = in_mon.ssid_present;
        ev.store_ok         = in_mon.store_ok;
        predicted_status.push_back(advance_link(ev));
      end
    end
    pending = predicted_status.size();
  end

endmodule

FILE: verif/wireless_link_supervisor_tb.sv
`timescale 1ns / 1ps

// Top of the link supervisor testbench. This module only makes stimulus and
// gives the verdict; prediction and comparison live in wls_link_checker.
module wireless_link_supervisor_tb;
  import wls_pkg::*;

  // The two event codes that the block must ignore have no name in the package.
  localparam logic [2:0] FN_UNUSED_LO = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  // Every item yields one result. This limit only catches a hang: a correct run,
  // even with the receiver mostly stalled, never comes near it.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 250;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int pending;
  int fail_count;
  int cycles = 0;

  // State of the receiver's stall pattern.
  int stall_mode = 0;
  int stretch_left = 0;

  wls_in_if  in_chan ();
  wls_out_if out_chan ();

  wireless_link_supervisor DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  wls_link_checker link_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A hang, or a result that never arrives, ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("wireless_link_supervisor_tb: done, errors");
      $finish;
    end
  end

  // The receiver switches between stretches of its own: always ready, ready at
  // random half of the time, and mostly stalled. Stretch lengths are random, so
  // stalls land on every phase of the sender's bursts.
  always @(posedge clk) begin
    if (stretch_left == 0) begin
      stall_mode   = $urandom_range(0, 2);
      stretch_left = $urandom_range(5, 60);
    end else begin
      stretch_left--;
    end
    case (stall_mode)
      0:       out_chan.ready <= 1'b1;
      1:       out_chan.ready <= 1'($urandom_range(0, 1));
      default: out_chan.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Presents one event and holds it until the block takes it. Called right after
  // a rising edge; returns right after the edge at which the transfer happened.
  // valid is left high so that a burst flows without a bubble.
  task automatic send_event(in_item_t ev);
    in_chan.valid            <= 1'b1;
    in_chan.func             <= ev.func;
    in_chan.have_credentials <= ev.have_credentials;
    in_chan.ssid_present     <= ev.ssid_present;
    in_chan.store_ok         <= ev.store_ok;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic pause_input(int idle_cycles);
    in_chan.valid <= 1'b0;
    repeat (idle_cycles) @(posedge clk);
  endtask

  // Stops the sender and waits for every predicted result. valid is already low
  // at the first edge waited for, so no new prediction can appear meanwhile.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One register write: a setup phase, then an access phase whose closing edge
  // performs the write. The unused upper data bits carry noise that the block
  // must drop. The bus stays selected so that writes can follow each other;
  // configure releases it after the last one.
  task automatic write_register(logic [1:0] idx, logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] word;
    word              = $urandom();
    word[CFG_W-1:0]   = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] connect_to, logic [CFG_W-1:0] retry_iv,
                           logic [CFG_W-1:0] linger, logic [CFG_W-1:0] window);
    write_register(REG_CONNECT_TIMEOUT, connect_to);
    write_register(REG_RETRY_INTERVAL, retry_iv);
    write_register(REG_AP_LINGER, linger);
    write_register(REG_AP_WINDOW, window);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Ticks dominate, as they do in the field: with short timeouts they carry the
  // machine through attempts, timeouts, retries and access-point expiry. The
  // other events arrive often enough to break into every state, and a few
  // unused codes are mixed in as noise.
  function automatic in_item_t random_event();
    in_item_t ev;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      ev.func = FN_TICK;
    else if (pick < 65) ev.func = FN_GOT_ADDR;
    else if (pick < 73) ev.func = FN_DISCONN;
    else if (pick < 80) ev.func = FN_START;
    else if (pick < 87) ev.func = FN_RECONNECT;
    else if (pick < 96) ev.func = FN_SET_CRED;
    else if (pick < 98) ev.func = FN_UNUSED_LO;
    else                ev.func = FN_UNUSED_HI;
    ev.have_credentials = 1'($urandom_range(0, 1));
    ev.ssid_present     = 1'($urandom_range(0, 1));
    ev.store_ok         = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Random events in bursts of random length. Between bursts the sender either
  // carries straight on, pauses its input, or now and then waits until every
  // result is back.
  task automatic feed_events(int count);
    int sent;
    int burst;
    int pick;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_event(random_event());
        sent++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3)       drain_results();
      else if (pick < 70) pause_input($urandom_range(1, 8));
    end
    drain_results();
  endtask

  initial begin
    logic [CFG_W-1:0] connect_to;
    logic [CFG_W-1:0] retry_iv;
    logic [CFG_W-1:0] linger;
    logic [CFG_W-1:0] window;

    rst_n                    <= 1'b0;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    in_chan.valid            <= 1'b0;
    in_chan.func             <= FN_TICK;
    in_chan.have_credentials <= 1'b0;
    in_chan.ssid_present     <= 1'b0;
    in_chan.store_ok         <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk with the reset configuration. It starts with the events that
    // must change nothing: unused codes, a tick while idle, a reconnect with no
    // credentials and a set-credentials request with no network name.
    send_event(in_item_t'{FN_UNUSED_LO, 1'b0, 1'b0, 1'b0});
    send_event(in_item_t'{FN_UNUSED_HI, 1'b1, 1'b1, 1'b1});
    send_event(in_item_t'{FN_TICK, 1'b0, 1'b0, 1'b0});
    send_event(in_item_t'{FN_RECONNECT, 1'b1, 1'b1, 1'b1});
    send_event(in_item_t'{FN_SET_CRED, 1'b1, 1'b0, 1'b1});
    // Address events outside a tick only move the held flag.
    send_event(in_item_t'{FN_GOT_ADDR, 1'b0, 1'b0, 1'b0});
    send_event(in_item_t'{FN_DISCONN, 1'b0, 1'b0, 1'b0});
    // Start without credentials enters the portal and raises the access point;
    // a second one finds it up already and must not reload its window.
    send_event(in_item_t'{FN_START, 1'b0, 1'b1, 1'b1});
    send_event(in_item_t'{FN_START, 1'b0, 1'b0, 1'b0});
    send_event(in_item_t'{FN_TICK, 1'b1, 1'b1, 1'b1});
    // A failed store still remembers the credentials, so the reconnect that
    // follows is accepted.
    send_event(in_item_t'{FN_SET_CRED, 1'b0, 1'b1, 1'b0});
    send_event(in_item_t'{FN_RECONNECT, 1'b0, 1'b0, 1'b0});
    send_event(in_item_t'{FN_TICK, 1'b0, 1'b0, 1'b0});
    send_event(in_item_t'{FN_GOT_ADDR, 1'b1, 1'b1, 1'b1});
    send_event(in_item_t'{FN_TICK, 1'b0, 1'b0, 1'b0});
    send_event(in_item_t'{FN_TICK, 1'b0, 1'b0, 1'b0});
    // Losing the address while online sends the link to retry wait.
    send_event(in_item_t'{FN_DISCONN, 1'b1, 1'b1, 1'b1});
    send_event(in_item_t'{FN_TICK, 1'b0, 1'b0, 1'b0});
    // Start with credentials restarts an attempt from any state; so does a
    // successful set-credentials request.
    send_event(in_item_t'{FN_START, 1'b1, 1'b0, 1'b0});
    send_event(in_item_t'{FN_SET_CRED, 1'b0, 1'b1, 1'b1});
    send_event(in_item_t'{FN_GOT_ADDR, 1'b0, 1'b0, 1'b0});
    send_event(in_item_t'{FN_TICK, 1'b1, 1'b1, 1'b1});
    drain_results();

    // Random phases, each under its own configuration. The registers are only
    // written here, after the previous phase has drained. The first two phases
    // take the extremes: all zero, where every countdown expires at the next
    // tick, and all ones. The rest use short timeouts so that attempts,
    // retries and access-point windows run out many times per phase.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        connect_to = '0;
        retry_iv   = '0;
        linger     = '0;
        window     = '0;
      end else if (phase == 1) begin
        connect_to = '1;
        retry_iv   = '1;
        linger     = '1;
        window     = '1;
      end else begin
        connect_to = CFG_W'($urandom_range(1, 12));
        retry_iv   = CFG_W'($urandom_range(1, 20));
        linger     = CFG_W'($urandom_range(0, 15));
        window     = CFG_W'($urandom_range(1, 40));
      end
      configure(connect_to, retry_iv, linger, window);
      feed_events(ITEMS_PER_PHASE);
    end

    // Everything has come back; the wait below lets the two-stage pipeline show
    // any stray result before the verdict.
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("wireless_link_supervisor_tb: done, clean");
    end else begin
      $display("wireless_link_supervisor_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/wls_pkg.sv
src/wls_if.sv
src/wls_cfg.sv
src/wls_core.sv
src/wireless_link_supervisor.sv
verif/wls_link_checker.sv
verif/wireless_link_supervisor_tb.sv
